>>> hw/rtl/hid_usage_list_lookup_core_assert.svh
// Assertion macros for the HID usage list lookup core.
// Depends on nothing; included by the top level only.
`ifndef HID_USAGE_LIST_LOOKUP_CORE_ASSERT_SVH
`define HID_USAGE_LIST_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HULU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HULU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/hulu_pkg.sv
// Shared types and constants for the HID usage list lookup core.
// No dependencies; used by hulu_step and hid_usage_list_lookup_core.
`timescale 1ns / 1ps

package hulu_pkg;

  localparam int DefaultTableDepth = 256;
  localparam int SlotSpace         = 256;   // codes of an 8-bit slot field
  localparam int IndexW            = 24;
  localparam logic [IndexW-1:0] IndexMax = {IndexW{1'b1}};

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  entry_addr;
    logic        entry_is_range;
    logic [15:0] entry_page;
    logic [15:0] entry_min;
    logic [15:0] entry_max;
    logic [7:0]  first_entry;
    logic [8:0]  entry_count;
    logic [15:0] report_count;
    logic [15:0] query_page;
    logic [15:0] query_usage;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] usage_index;
    logic [15:0]       usage_count;
  } out_t;

  typedef struct packed {
    logic        is_range;
    logic [15:0] page;
    logic [15:0] umin;
    logic [15:0] umax;
  } entry_t;

  typedef struct packed {
    logic [15:0] report_count;
    logic [15:0] page;
    logic [15:0] usage;
  } query_t;

  // Result of one evaluation step of the shared unit.
  typedef struct packed {
    logic              hit;
    logic [IndexW-1:0] index;   // hit index, or next running index on a miss
    logic [15:0]       count;
  } step_res_t;

endpackage

>>> hw/rtl/hid_usage_list_lookup_core.sv
// Top level of the HID usage list lookup core: sequencer, table RAM, output register.
// Depends on hulu_pkg, hulu_ram, hulu_step and hid_usage_list_lookup_core_assert.svh.
`timescale 1ns / 1ps

// A write transaction stores one usage entry in the table RAM and returns no
// result. A query transaction walks entry_count table slots starting at
// first_entry, one slot per cycle through the table RAM's read port and the
// shared step unit, and stops at the first hit. Its result is offered when the
// walk ends, or later while an earlier result still waits in the output
// register; the input is not ready while a query is in progress. A finished
// result waits in the output register while the next transaction is accepted.
// The table is not cleared at reset: query only slots that were written.
module hid_usage_list_lookup_core #(
  parameter int TABLE_DEPTH = hulu_pkg::DefaultTableDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hulu_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hulu_pkg::out_t  out_o
);
  import hulu_pkg::*;

  `include "hid_usage_list_lookup_core_assert.svh"

  localparam int AddrW = $clog2(TABLE_DEPTH);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;
  localparam logic [1:0] StWalk  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  slot_q, slot_d, slot_next;
  logic [8:0]        remain_q, remain_d;
  logic [IndexW-1:0] run_q, run_d;
  query_t            query_q, query_d;
  out_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              in_fire;
  logic              query_fire;
  logic              ram_we;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [AddrW-1:0]  slot_lut [SlotSpace];
  step_res_t         step_res;

  logic              walk_started;
  logic              done_hit;
  logic              done_miss;
  logic              miss_clear;

  // Slot reduction modulo the table depth, resolved at elaboration.
  for (genvar g = 0; g < SlotSpace; g++) begin : g_slot_lut
    localparam logic [AddrW-1:0] SlotMod = AddrW'(g % TABLE_DEPTH);
    assign slot_lut[g] = SlotMod;
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign query_fire = in_fire && (in_i.opcode == OpQuery);
  assign ram_we     = in_fire && (in_i.opcode == OpWrite);

  assign wr_entry.is_range = in_i.entry_is_range;
  assign wr_entry.page     = in_i.entry_page;
  assign wr_entry.umin     = in_i.entry_min;
  assign wr_entry.umax     = in_i.entry_max;

  hulu_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_lut[in_i.entry_addr]),
    .wdata_i (wr_entry),
    .raddr_i (slot_q),
    .rdata_o (rd_entry)
  );

  hulu_step u_step (
    .entry_i (rd_entry),
    .query_i (query_q),
    .run_i   (run_q),
    .last_i  (remain_q == 9'd1),
    .res_o   (step_res)
  );

  assign slot_next = (slot_q == AddrW'(TABLE_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    remain_d    = remain_q;
    run_d       = run_q;
    query_d     = query_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      StIdle: begin
        if (query_fire) begin
          slot_d               = slot_lut[in_i.first_entry];
          remain_d             = in_i.entry_count;
          run_d                = '0;
          query_d.report_count = in_i.report_count;
          query_d.page         = in_i.query_page;
          query_d.usage        = in_i.query_usage;
          res_d                = '0;
          state_d              = (in_i.entry_count == 9'd0) ? StDone : StFetch;
        end
      end
      StFetch: begin
        slot_d  = slot_next;
        state_d = StWalk;
      end
      StWalk: begin
        // Read data holds the entry addressed in the previous cycle.
        slot_d   = slot_next;
        remain_d = remain_q - 9'd1;
        run_d    = step_res.index;
        if (step_res.hit) begin
          res_d.found       = 1'b1;
          res_d.usage_index = step_res.index;
          res_d.usage_count = step_res.count;
          state_d           = StDone;
        end else if (remain_q == 9'd1) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      remain_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      remain_q    <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    run_q   <= run_d;
    query_q <= query_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign walk_started = (state_q == StFetch) || (state_q == StDone);
  assign done_hit     = (state_q == StDone) && res_q.found;
  assign done_miss    = (state_q == StDone) && !res_q.found;
  assign miss_clear   = (res_q.usage_index == '0) && (res_q.usage_count == 16'd0);

  `HULU_ASSERT_IMP(a_walk_nonempty, clk_i, rst_ni, state_q == StWalk, remain_q != '0, "empty walk")
  `HULU_ASSERT_NXT(a_query_starts, clk_i, rst_ni, query_fire, walk_started, "query did not start")
  `HULU_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, done_miss, miss_clear, "miss not cleared")
  `HULU_ASSERT_IMP(a_hit_count, clk_i, rst_ni, done_hit, res_q.usage_count != '0, "zero count")

endmodule

>>> hw/rtl/hulu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hulu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/hulu_step.sv
// Shared evaluation unit: matches one table entry and advances the running index.
// Depends on hulu_pkg.
`timescale 1ns / 1ps

module hulu_step (
  input  hulu_pkg::entry_t                 entry_i,
  input  hulu_pkg::query_t                 query_i,
  input  logic [hulu_pkg::IndexW-1:0]      run_i,
  input  logic                             last_i,
  output hulu_pkg::step_res_t              res_o
);
  import hulu_pkg::*;

  logic              on_page;
  logic              in_range;
  logic              hit;
  logic [16:0]       span;
  logic [16:0]       addend;
  logic [IndexW:0]   sum;
  logic [IndexW-1:0] sat_sum;
  logic [25:0]       left;
  logic              use_left;

  always_comb begin
    on_page  = (query_i.page == 16'd0) || (query_i.page == entry_i.page);
    in_range = (query_i.usage >= entry_i.umin) && (query_i.usage <= entry_i.umax);
    if (entry_i.is_range) begin
      hit = in_range && on_page;
    end else begin
      hit = (query_i.usage == entry_i.umin) && on_page;
    end

    // Inverted ranges still advance by their absolute span.
    if (entry_i.umax >= entry_i.umin) begin
      span = {1'b0, entry_i.umax - entry_i.umin};
    end else begin
      span = {1'b0, entry_i.umin - entry_i.umax};
    end

    // One adder serves both the hit offset and the miss advance.
    if (entry_i.is_range) begin
      addend = hit ? {1'b0, query_i.usage - entry_i.umin} : span + 17'd1;
    end else begin
      addend = hit ? 17'd0 : 17'd1;
    end
    sum     = {1'b0, run_i} + (IndexW + 1)'(addend);
    sat_sum = (sum > (IndexW + 1)'(IndexMax)) ? IndexMax : sum[IndexW-1:0];

    // Remaining elements for the last entry; a range also drops its own slot.
    left     = 26'(query_i.report_count) - 26'(run_i) - 26'(entry_i.is_range);
    use_left = last_i && (!entry_i.is_range || (query_i.usage == entry_i.umax));

    res_o.hit   = hit;
    res_o.index = sat_sum;
    if (use_left && ($signed(left) > 26'sd1)) begin
      res_o.count = left[15:0];
    end else begin
      res_o.count = 16'd1;
    end
  end

endmodule
